>>> rtl/core/trace_buffer_writer_with_timestamps_core_defines.svh
// Assertion macros shared by the trace buffer writer RTL.
// Needs nothing else; the asserting module must have clk and arst_n.
`ifndef TRACE_BUFFER_WRITER_WITH_TIMESTAMPS_CORE_DEFINES_SVH
`define TRACE_BUFFER_WRITER_WITH_TIMESTAMPS_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Clocked assertion, disabled while reset is applied.
`define TBW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// Condition that must never be true at a clock edge.
`define TBW_ASSERT_NEVER(label, cond, msg) \
	`TBW_ASSERT(label, !(cond), msg)
`else
`define TBW_ASSERT(label, prop, msg)
`define TBW_ASSERT_NEVER(label, cond, msg)
`endif
`endif

>>> rtl/core/tbw_pkg.sv
// Package of the trace buffer writer: widths, item and result types, register codes
// and the timestamp digit helpers. Depends on nothing.
package tbw_pkg;

	// Buffer address width and the widths of the fixed fields.
	localparam int AddrWidth = 16;
	localparam int SizeWidth = 17;
	localparam int CharWidth = 8;
	localparam int TimeWidth = 63;
	localparam int DataWidth = 32;
	localparam int PaddrWidth = 4;

	// Timestamp layout: nine 7-bit digits, most significant first, bit 7 set.
	localparam int NumDigits = 9;
	localparam int DigitWidth = 7;
	localparam int PhaseWidth = $clog2(NumDigits);
	localparam logic [PhaseWidth-1:0] LastDigit = PhaseWidth'(NumDigits - 1);
	localparam logic [CharWidth-1:0] DigitMark = 8'h80;
	localparam logic [CharWidth-1:0] NewlineChar = 8'd10;

	// Reset value of the buffer size register.
	localparam logic [SizeWidth-1:0] BufSizeReset = 17'h10000;

	// Queue depths.
	localparam int ItemQDepth = 4;
	localparam int ItemQPtrWidth = $clog2(ItemQDepth);
	localparam int ResQDepth = 2;
	localparam int ResQPtrWidth = $clog2(ResQDepth);

	// Width used to compare the size register against the address range.
	localparam int CmpWidth = (SizeWidth > AddrWidth + 1) ? SizeWidth : AddrWidth + 1;

	typedef enum logic [1:0] {
		REG_BUFFER_SIZE = 2'd0,
		REG_WRAP_ENABLE = 2'd1,
		REG_LOG_ENABLE  = 2'd2
	} reg_idx_t;

	// One accepted character with its time and its class.
	typedef struct packed {
		logic [CharWidth-1:0] char_byte;
		logic [TimeWidth-1:0] time_now;
		logic                 is_newline;
	} item_t;

	// One buffer write.
	typedef struct packed {
		logic [AddrWidth-1:0] write_addr;
		logic [CharWidth-1:0] write_byte;
		logic                 last;
		logic                 wrapped_flag;
		logic                 stopped_flag;
	} result_t;

	// Configuration seen by the write sequencer.
	typedef struct packed {
		logic [AddrWidth:0] eff_size;
		logic               wrap_enable;
		logic               log_enable;
		logic               stop_clr;
	} tbw_cfg_t;

	// Effective buffer size: zero counts as one, capped at the address range.
	function automatic logic [AddrWidth:0] eff_size(input logic [SizeWidth-1:0] size);
		logic [CmpWidth-1:0] s;
		logic [CmpWidth-1:0] cap;
		s = CmpWidth'(size);
		cap = CmpWidth'(1) << AddrWidth;
		if (s == '0) begin
			s = CmpWidth'(1);
		end
		if (s > cap) begin
			s = cap;
		end
		return (AddrWidth + 1)'(s);
	endfunction

	// Timestamp byte for digit position k.
	function automatic logic [CharWidth-1:0] stamp_digit(input logic [TimeWidth-1:0] t,
			input logic [PhaseWidth-1:0] k);
		logic [DigitWidth-1:0] d;
		d = '0;
		for (int i = 0; i < NumDigits; i++) begin
			if (k == PhaseWidth'(i)) begin
				d = t[TimeWidth - DigitWidth * (i + 1) +: DigitWidth];
			end
		end
		return DigitMark | CharWidth'(d);
	endfunction

endpackage

>>> rtl/core/tbw_front.sv
// Front end of the trace buffer writer: accepts characters, marks newlines and
// holds them in a short queue for the write sequencer. Depends on tbw_pkg.
module tbw_front import tbw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [CharWidth-1:0] char_byte,
	input  logic [TimeWidth-1:0] time_now,
	output logic                 full,
	input  logic                 pop,
	output item_t                head,
	output logic                 empty
);

	item_t                  entry_q [ItemQDepth];
	logic [ItemQPtrWidth-1:0] wr_ptr_q;
	logic [ItemQPtrWidth-1:0] rd_ptr_q;
	logic [ItemQPtrWidth:0]   count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full = (count_q == (ItemQPtrWidth + 1)'(ItemQDepth));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the character, classified as it is taken in.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q].char_byte <= char_byte;
			entry_q[wr_ptr_q].time_now <= time_now;
			entry_q[wr_ptr_q].is_newline <= (char_byte == NewlineChar);
		end
	end

endmodule

>>> rtl/core/tbw_back.sv
// Write sequencer of the trace buffer writer: turns queued characters into buffer
// writes, with line timestamps and wrap handling. Depends on tbw_pkg and the defines.
`include "trace_buffer_writer_with_timestamps_core_defines.svh"
module tbw_back import tbw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tbw_cfg_t cfg,
	input  item_t    head,
	input  logic     head_valid,
	output logic     item_pop,
	output logic     res_wr,
	output result_t  res,
	input  logic     res_room
);

	logic [AddrWidth-1:0]  idx_q;
	logic                  has_wrapped_q;
	logic                  at_line_start_q;
	logic                  stopped_q;
	logic [PhaseWidth-1:0] phase_q;
	logic                  active;
	logic                  emit;
	logic                  drop;
	logic [AddrWidth:0]    idx_inc;
	logic                  wrap_hit;
	logic                  stop_hit;

	// Decide what happens to the item at the head of the queue.
	always_comb begin
		active = cfg.log_enable && !stopped_q;
		emit = head_valid && active && res_room;
		drop = head_valid && !active;
		idx_inc = {1'b0, idx_q} + 1'b1;
		wrap_hit = (idx_inc >= cfg.eff_size);
		stop_hit = wrap_hit && !cfg.wrap_enable;
		item_pop = drop || (emit && (stop_hit || !at_line_start_q));
	end

	// Form the buffer write.
	always_comb begin
		res_wr = emit;
		res.write_addr = idx_q;
		res.write_byte = at_line_start_q ? stamp_digit(head.time_now, phase_q)
			: head.char_byte;
		res.last = stop_hit || !at_line_start_q;
		res.wrapped_flag = has_wrapped_q || wrap_hit;
		res.stopped_flag = stop_hit;
	end

	// Buffer index, marks and timestamp digit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			has_wrapped_q <= 1'b0;
			at_line_start_q <= 1'b1;
			stopped_q <= 1'b0;
			phase_q <= '0;
		end else begin
			if (emit) begin
				idx_q <= wrap_hit ? '0 : idx_inc[AddrWidth-1:0];
				if (wrap_hit) begin
					has_wrapped_q <= 1'b1;
				end
				if (stop_hit) begin
					stopped_q <= 1'b1;
				end
				if (at_line_start_q) begin
					if (stop_hit) begin
						phase_q <= '0;
					end else if (phase_q == LastDigit) begin
						phase_q <= '0;
						at_line_start_q <= 1'b0;
					end else begin
						phase_q <= phase_q + 1'b1;
					end
				end else if (head.is_newline) begin
					at_line_start_q <= 1'b1;
				end
			end
			if (cfg.stop_clr) begin
				stopped_q <= 1'b0;
			end
		end
	end

	`TBW_ASSERT(a_phase_in_stamp, (phase_q != '0) |-> at_line_start_q, "digit count outside a timestamp")
	`TBW_ASSERT(a_pop_has_last, (emit && item_pop) |-> res.last, "item finished without a last write")
	`TBW_ASSERT(a_last_pops, (emit && res.last) |-> item_pop, "last write left the item queued")
	`TBW_ASSERT_NEVER(a_no_write_stopped, stopped_q && res_wr, "write while logging is stopped")

endmodule

>>> rtl/core/tbw_res_queue.sv
// Result queue of the trace buffer writer: holds buffer writes until the consumer
// takes them. Depends on tbw_pkg.
module tbw_res_queue import tbw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  result_t wr_data,
	output logic    room,
	input  logic    pop,
	output logic    empty,
	output result_t head
);

	result_t                 entry_q [ResQDepth];
	logic [ResQPtrWidth-1:0] wr_ptr_q;
	logic [ResQPtrWidth-1:0] rd_ptr_q;
	logic [ResQPtrWidth:0]   count_q;
	logic                    do_push;
	logic                    do_pop;

	assign room = (count_q != (ResQPtrWidth + 1)'(ResQDepth));
	assign empty = (count_q == '0);
	assign do_push = wr_en && room;
	assign do_pop = pop && !empty;
	assign head = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Result storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> rtl/core/trace_buffer_writer_with_timestamps_core.sv
// Trace buffer writer, top level: register port, input queue, write sequencer and
// result queue. Depends on tbw_pkg, tbw_front, tbw_back and tbw_res_queue.
//
// Each transfer on the input side carries one log character and the current time;
// each transfer on the result side is one byte write into the circular buffer.
// A character on a line that is already open gives one write; the first character
// of a line gives ten (nine timestamp bytes, then the character). The sequencer has
// one write port and makes one write per cycle while the result queue has room; a
// character is discarded without a write while logging is off or stopped. A character
// is held in the input queue and its writes in the result queue before they reach the
// result side; the sequencer between the two queues is combinational. Four
// characters and two writes can wait in the queues. No clearing pass follows reset.
module trace_buffer_writer_with_timestamps_core import tbw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Character input
	input  logic                  push,
	output logic                  full,
	input  logic [CharWidth-1:0]  char_byte,
	input  logic [TimeWidth-1:0]  time_now,
	// Buffer writes
	output logic                  empty,
	input  logic                  pop,
	output logic [AddrWidth-1:0]  write_addr,
	output logic [CharWidth-1:0]  write_byte,
	output logic                  last,
	output logic                  wrapped_flag,
	output logic                  stopped_flag,
	// Register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PaddrWidth-1:0] paddr,
	input  logic [DataWidth-1:0]  pwdata,
	output logic [DataWidth-1:0]  prdata,
	output logic                  pready
);

	logic [SizeWidth-1:0] buffer_size_q;
	logic                 wrap_enable_q;
	logic                 log_enable_q;
	logic                 cfg_wr;
	reg_idx_t             reg_idx;
	tbw_cfg_t             cfg;
	item_t                item_head;
	logic                 item_empty;
	logic                 item_pop;
	logic                 res_wr;
	result_t              res_in;
	logic                 res_room;
	result_t              res_head;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PaddrWidth-1:2]);
	assign cfg_wr = psel && penable && pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= BufSizeReset;
			wrap_enable_q <= 1'b0;
			log_enable_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_BUFFER_SIZE: buffer_size_q <= pwdata[SizeWidth-1:0];
				REG_WRAP_ENABLE: wrap_enable_q <= pwdata[0];
				REG_LOG_ENABLE:  log_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (reg_idx)
			REG_BUFFER_SIZE: prdata = DataWidth'(buffer_size_q);
			REG_WRAP_ENABLE: prdata = DataWidth'(wrap_enable_q);
			REG_LOG_ENABLE:  prdata = DataWidth'(log_enable_q);
			default:         prdata = '0;
		endcase
	end

	// A write to the enable register restarts a stopped log.
	always_comb begin
		cfg.eff_size = eff_size(buffer_size_q);
		cfg.wrap_enable = wrap_enable_q;
		cfg.log_enable = log_enable_q;
		cfg.stop_clr = cfg_wr && (reg_idx == REG_LOG_ENABLE);
	end

	tbw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.char_byte (char_byte),
		.time_now  (time_now),
		.full      (full),
		.pop       (item_pop),
		.head      (item_head),
		.empty     (item_empty)
	);

	tbw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (item_head),
		.head_valid (!item_empty),
		.item_pop   (item_pop),
		.res_wr     (res_wr),
		.res        (res_in),
		.res_room   (res_room)
	);

	tbw_res_queue u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_data (res_in),
		.room    (res_room),
		.pop     (pop),
		.empty   (empty),
		.head    (res_head)
	);

	// Result fields.
	assign write_addr = res_head.write_addr;
	assign write_byte = res_head.write_byte;
	assign last = res_head.last;
	assign wrapped_flag = res_head.wrapped_flag;
	assign stopped_flag = res_head.stopped_flag;

endmodule
